// ===== rtl/bgd_pkg.sv =====
// shared types, constants and helpers of the button gesture detector
package bgd_pkg;

    localparam int PIN_W       = 4;
    localparam int BTN_W       = 2;
    localparam int TICK_W      = 32;
    localparam int TIME_W      = 16;
    localparam int CNT_W       = 3;
    localparam int CLICK_W     = 2;
    localparam int KIND_W      = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CNT_W-1:0]   DEBOUNCE_TOP = 3'd4;
    localparam logic [CNT_W-1:0]   IDLE_EXIT    = 3'd5;
    localparam logic [CNT_W-1:0]   CNT_MAX      = 3'd7;
    localparam logic [CLICK_W-1:0] CLICK_MAX    = 2'd3;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_TICKS       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_POWER_HOLD_TICKS = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DOUBLE_CLICK     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SLOW_REPEAT      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FAST_REPEAT      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_FAST_AFTER       = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_BUTTON_MODES     = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_OVERRIDE_MASK    = 3'd7;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_AUTO   = 2'd1,
        MODE_POWER  = 2'd2
    } mode_t;

    typedef enum logic [KIND_W-1:0] {
        EV_NONE    = 3'd0,
        EV_PRESS   = 3'd1,
        EV_HOLD    = 3'd2,
        EV_DOUBLE  = 3'd3,
        EV_REPEAT  = 3'd4,
        EV_RELEASE = 3'd5,
        EV_WAKE    = 3'd6
    } event_kind_t;

    typedef struct packed {
        logic [PIN_W-1:0] pin_levels;
        logic             fast_screen;
        logic             system_sleeping;
    } poll_t;

    typedef struct packed {
        logic [KIND_W-1:0] event_kind;
        logic [BTN_W-1:0]  event_button;
        logic              busy_res;
    } gesture_t;

    // classified poll tick handed from front to back
    typedef struct packed {
        logic [PIN_W-1:0]  pin_levels;
        logic              fast_screen;
        logic              system_sleeping;
        logic              start;
        logic [BTN_W-1:0]  start_button;
        logic [TICK_W-1:0] now;
    } item_t;

    typedef struct packed {
        logic [TIME_W-1:0]  hold_ticks;
        logic [TIME_W-1:0]  power_hold_ticks;
        logic [TIME_W-1:0]  double_click_ticks;
        logic [TIME_W-1:0]  slow_repeat_ticks;
        logic [TIME_W-1:0]  fast_repeat_ticks;
        logic [CNT_W-1:0]   fast_after_repeats;
        logic [2*PIN_W-1:0] button_modes;
        logic [PIN_W-1:0]   override_mask;
    } cfg_t;

    typedef struct packed {
        logic               active;
        logic [BTN_W-1:0]   current_button;
        logic [CNT_W-1:0]   debounce_cnt;
        logic               is_down;
        logic               hold_fired;
        logic [CLICK_W-1:0] clicks;
        logic [CNT_W-1:0]   repeats;
        logic [CNT_W-1:0]   idle_ticks;
        logic [TICK_W-1:0]  press_stamp;
        logic [TICK_W-1:0]  release_stamp;
        logic [TICK_W-1:0]  repeat_stamp;
    } state_t;

    // first event raised in a tick wins
    function automatic event_kind_t raise(input event_kind_t cur, input event_kind_t kind);
        raise = (cur == EV_NONE) ? kind : cur;
    endfunction

endpackage

// ===== rtl/bgd_stream_if.sv =====
// valid/ready channel carrying one payload per transaction
interface bgd_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/bgd_front.sv =====
// front end: edge detection, start button pick and tick stamping
module bgd_front #(
    parameter int NUM_BUTTONS = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    bgd_stream_if.sink   poll,
    bgd_stream_if.source items
);
    localparam int LANES = (NUM_BUTTONS < bgd_pkg::PIN_W) ? NUM_BUTTONS : bgd_pkg::PIN_W;
    localparam logic [bgd_pkg::PIN_W-1:0] LANE_MASK = bgd_pkg::PIN_W'((1 << LANES) - 1);

    logic [bgd_pkg::PIN_W-1:0]  prev_levels_reg, prev_levels_next;
    logic [bgd_pkg::TICK_W-1:0] tick_reg, tick_next;
    logic [bgd_pkg::PIN_W-1:0]  falling;
    logic [bgd_pkg::BTN_W-1:0]  first_btn;
    logic                       accept;
    bgd_pkg::poll_t             p;
    bgd_pkg::item_t             it;

    assign p      = poll.data;
    assign accept = poll.valid && poll.ready;

    assign falling = prev_levels_reg & ~p.pin_levels & LANE_MASK;

    // lowest index wins
    always_comb
    begin
        first_btn = '0;
        for (int i = bgd_pkg::PIN_W - 1; i >= 0; i--)
        begin
            if (falling[i])
            begin
                first_btn = bgd_pkg::BTN_W'(i);
            end
        end
    end

    always_comb
    begin
        it.pin_levels      = p.pin_levels;
        it.fast_screen     = p.fast_screen;
        it.system_sleeping = p.system_sleeping;
        it.start           = |falling;
        it.start_button    = first_btn;
        it.now             = tick_reg;
    end

    assign items.valid = poll.valid;
    assign items.data  = it;
    assign poll.ready  = items.ready;

    always_comb
    begin
        prev_levels_next = prev_levels_reg;
        tick_next        = tick_reg;
        if (accept)
        begin
            prev_levels_next = p.pin_levels;
            tick_next        = tick_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_levels_reg <= '1;
            tick_reg        <= '0;
        end
        else
        begin
            prev_levels_reg <= prev_levels_next;
            tick_reg        <= tick_next;
        end
    end
endmodule

// ===== rtl/bgd_queue.sv =====
// two-entry queue between front and back
module bgd_queue (
    input  logic         clk,
    input  logic         rst_n,
    bgd_stream_if.sink   push,
    bgd_stream_if.source pop
);
    bgd_pkg::item_t                mem_reg [bgd_pkg::QUEUE_DEPTH];
    logic [bgd_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [bgd_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [bgd_pkg::QCNT_W-1:0]    count_reg, count_next;
    logic                          do_push, do_pop;

    assign push.ready = (count_reg != bgd_pkg::QCNT_W'(bgd_pkg::QUEUE_DEPTH));
    assign pop.valid  = (count_reg != '0);
    assign pop.data   = mem_reg[rd_ptr_reg];

    assign do_push = push.valid && push.ready;
    assign do_pop  = pop.valid && pop.ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end
endmodule

// ===== rtl/bgd_back.sv =====
// back end: debounce integrator, gesture tracking and result register
module bgd_back (
    input  logic           clk,
    input  logic           rst_n,
    input  bgd_pkg::cfg_t  cfg,
    bgd_stream_if.sink     items,
    bgd_stream_if.source   gesture
);
    bgd_pkg::state_t   st_reg, st_next;
    bgd_pkg::gesture_t out_reg, out_next;
    logic              out_valid_reg, out_valid_next;
    logic              take;

    bgd_pkg::item_t    it;
    bgd_pkg::state_t   s;
    bgd_pkg::event_kind_t ev;
    bgd_pkg::mode_t    mode;
    logic [1:0]        mcode;
    logic              raw, deb, ended;
    logic [bgd_pkg::TIME_W-1:0] limit, interval;

    assign it          = items.data;
    assign items.ready = !out_valid_reg || gesture.ready;
    assign take        = items.valid && items.ready;

    assign gesture.valid = out_valid_reg;
    assign gesture.data  = out_reg;

    always_comb
    begin
        s        = st_reg;
        ev       = bgd_pkg::EV_NONE;
        ended    = 1'b0;
        mode     = bgd_pkg::MODE_NORMAL;
        mcode    = '0;
        raw      = 1'b0;
        deb      = 1'b0;
        limit    = '0;
        interval = '0;

        if (!s.active && it.start)
        begin
            s.current_button = it.start_button;
            s.active         = 1'b1;
            s.debounce_cnt   = '0;
            s.is_down        = 1'b0;
            s.hold_fired     = 1'b0;
            s.clicks         = '0;
            s.repeats        = '0;
            s.idle_ticks     = '0;
        end

        if (s.active)
        begin
            mcode = cfg.button_modes[{s.current_button, 1'b0} +: 2];
            case (mcode)
                bgd_pkg::MODE_AUTO:  mode = bgd_pkg::MODE_AUTO;
                bgd_pkg::MODE_POWER: mode = bgd_pkg::MODE_POWER;
                default:             mode = bgd_pkg::MODE_NORMAL;
            endcase
            if (it.fast_screen && cfg.override_mask[s.current_button])
            begin
                mode = bgd_pkg::MODE_AUTO;
            end
            raw = !it.pin_levels[s.current_button];

            if (!raw && !s.is_down)
            begin
                if (s.idle_ticks < bgd_pkg::CNT_MAX)
                begin
                    s.idle_ticks = s.idle_ticks + 1'b1;
                end
            end
            else
            begin
                s.idle_ticks = '0;
            end

            // up/down integrator
            if (raw)
            begin
                if (s.debounce_cnt < bgd_pkg::DEBOUNCE_TOP)
                begin
                    s.debounce_cnt = s.debounce_cnt + 1'b1;
                end
            end
            else if (s.debounce_cnt != '0)
            begin
                s.debounce_cnt = s.debounce_cnt - 1'b1;
            end
            deb = (s.debounce_cnt >= bgd_pkg::DEBOUNCE_TOP);

            if (deb != s.is_down)
            begin
                if (deb)
                begin
                    s.is_down     = 1'b1;
                    s.press_stamp = it.now;
                    if (it.system_sleeping)
                    begin
                        ev             = bgd_pkg::raise(ev, bgd_pkg::EV_WAKE);
                        s.debounce_cnt = '0;
                        ended          = 1'b1;
                    end
                    else
                    begin
                        s.repeat_stamp = it.now;
                        s.hold_fired   = 1'b0;
                        if (s.clicks < bgd_pkg::CLICK_MAX)
                        begin
                            s.clicks = s.clicks + 1'b1;
                        end
                    end
                end
                else
                begin
                    s.is_down       = 1'b0;
                    s.release_stamp = it.now;
                    if (mode == bgd_pkg::MODE_NORMAL)
                    begin
                        if (!s.hold_fired)
                        begin
                            ev = bgd_pkg::raise(ev, bgd_pkg::EV_PRESS);
                        end
                        s.clicks = '0;
                    end
                    else if (s.hold_fired)
                    begin
                        s.clicks = '0;
                    end
                    else if (s.clicks == 2'd2)
                    begin
                        ev       = bgd_pkg::raise(ev, bgd_pkg::EV_DOUBLE);
                        s.clicks = '0;
                    end
                end
            end

            if (!ended)
            begin
                if (s.is_down)
                begin
                    limit = (mode == bgd_pkg::MODE_POWER) ? cfg.power_hold_ticks
                                                          : cfg.hold_ticks;
                    interval = (s.repeats >= cfg.fast_after_repeats) ? cfg.fast_repeat_ticks
                                                                     : cfg.slow_repeat_ticks;
                    if (!s.hold_fired &&
                        (it.now - s.press_stamp) >= bgd_pkg::TICK_W'(limit))
                    begin
                        s.hold_fired = 1'b1;
                        if (mode == bgd_pkg::MODE_AUTO)
                        begin
                            ev             = bgd_pkg::raise(ev, bgd_pkg::EV_REPEAT);
                            s.repeat_stamp = it.now;
                            s.repeats      = 3'd1;
                            s.clicks       = '0;
                        end
                        else
                        begin
                            ev = bgd_pkg::raise(ev, bgd_pkg::EV_HOLD);
                        end
                    end
                    else if (s.hold_fired && mode == bgd_pkg::MODE_AUTO)
                    begin
                        if ((it.now - s.repeat_stamp) >= bgd_pkg::TICK_W'(interval))
                        begin
                            ev             = bgd_pkg::raise(ev, bgd_pkg::EV_REPEAT);
                            s.repeat_stamp = it.now;
                            if (s.repeats < bgd_pkg::CNT_MAX)
                            begin
                                s.repeats = s.repeats + 1'b1;
                            end
                        end
                    end
                end
                else if (mode != bgd_pkg::MODE_NORMAL && s.clicks == 2'd1)
                begin
                    if ((it.now - s.release_stamp) >=
                        bgd_pkg::TICK_W'(cfg.double_click_ticks))
                    begin
                        ev       = bgd_pkg::raise(ev, bgd_pkg::EV_PRESS);
                        s.clicks = '0;
                    end
                end

                if (!s.is_down && s.idle_ticks > bgd_pkg::IDLE_EXIT)
                begin
                    if (mode == bgd_pkg::MODE_NORMAL)
                    begin
                        ended = 1'b1;
                    end
                    else if (s.clicks == '0)
                    begin
                        if (s.hold_fired && mode == bgd_pkg::MODE_AUTO)
                        begin
                            ev = bgd_pkg::raise(ev, bgd_pkg::EV_RELEASE);
                        end
                        ended = 1'b1;
                    end
                end
            end

            if (ended)
            begin
                s.active = 1'b0;
            end
        end
    end

    always_comb
    begin
        st_next        = st_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (take)
        begin
            st_next               = s;
            out_next.event_kind   = ev;
            out_next.event_button = (ev != bgd_pkg::EV_NONE) ? s.current_button : '0;
            out_next.busy_res     = s.active;
            out_valid_next        = 1'b1;
        end
        else if (gesture.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

// ===== rtl/button_gesture_detector_core.sv =====
// top level of the button gesture detector
//
// poll carries one poll tick per transaction: four active-low pin levels, the
// fast-screen flag and the sleeping flag. gesture returns exactly one result
// per poll transaction, in order: event kind, button index and busy flag.
// Settings are written through cfg_we/cfg_index/cfg_data; the user must write
// them only while no tick is in flight, which the block does not enforce. A
// write lands at the clock edge where cfg_we is high. The front stage detects
// falling edges, picks the lowest falling button and stamps each tick with a
// 32-bit tick count; a two-entry queue feeds the back stage, which runs debounce
// and gesture tracking and registers the result. Throughput is one tick per
// cycle while gesture does not stall. When gesture stalls, the result register
// holds, the queue takes up to two more ticks and then poll.ready falls until
// the receiver drains. Reset clears the gesture state, the tick count and the
// queue, sets previous pin levels to all released and loads the default
// settings.
module button_gesture_detector_core #(
    parameter int NUM_BUTTONS = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    bgd_stream_if.sink                         poll,
    bgd_stream_if.source                       gesture,
    input  logic                               cfg_we,
    input  logic [bgd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bgd_pkg::CFG_DATA_W-1:0]     cfg_data
);
    bgd_pkg::cfg_t cfg_reg, cfg_next;

    bgd_stream_if #(.T(bgd_pkg::item_t)) front_q ();
    bgd_stream_if #(.T(bgd_pkg::item_t)) q_back ();

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                bgd_pkg::REG_HOLD_TICKS:       cfg_next.hold_ticks         = cfg_data;
                bgd_pkg::REG_POWER_HOLD_TICKS: cfg_next.power_hold_ticks   = cfg_data;
                bgd_pkg::REG_DOUBLE_CLICK:     cfg_next.double_click_ticks = cfg_data;
                bgd_pkg::REG_SLOW_REPEAT:      cfg_next.slow_repeat_ticks  = cfg_data;
                bgd_pkg::REG_FAST_REPEAT:      cfg_next.fast_repeat_ticks  = cfg_data;
                bgd_pkg::REG_FAST_AFTER:
                    cfg_next.fast_after_repeats = cfg_data[bgd_pkg::CNT_W-1:0];
                bgd_pkg::REG_BUTTON_MODES:
                    cfg_next.button_modes = cfg_data[2*bgd_pkg::PIN_W-1:0];
                bgd_pkg::REG_OVERRIDE_MASK:
                    cfg_next.override_mask = cfg_data[bgd_pkg::PIN_W-1:0];
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_ticks         <= 16'd30;
            cfg_reg.power_hold_ticks   <= 16'd150;
            cfg_reg.double_click_ticks <= 16'd25;
            cfg_reg.slow_repeat_ticks  <= 16'd20;
            cfg_reg.fast_repeat_ticks  <= 16'd5;
            cfg_reg.fast_after_repeats <= 3'd5;
            cfg_reg.button_modes       <= 8'd128;
            cfg_reg.override_mask      <= 4'd3;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bgd_front #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .poll  (poll),
        .items (front_q)
    );

    bgd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_q),
        .pop   (q_back)
    );

    bgd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .items   (q_back),
        .gesture (gesture)
    );

    // no event means no button
    a_quiet_button: assert property (@(posedge clk) disable iff (!rst_n)
        (gesture.valid && gesture.data.event_kind == bgd_pkg::EV_NONE)
            |-> (gesture.data.event_button == '0))
        else $error("button index set without an event");

    // hold, repeat and double never end an interaction
    a_mid_events_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (gesture.valid && (gesture.data.event_kind == bgd_pkg::EV_HOLD ||
                           gesture.data.event_kind == bgd_pkg::EV_REPEAT ||
                           gesture.data.event_kind == bgd_pkg::EV_DOUBLE))
            |-> gesture.data.busy_res)
        else $error("mid-interaction event reported as idle");

    // wake always ends the interaction
    a_wake_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (gesture.valid && gesture.data.event_kind == bgd_pkg::EV_WAKE)
            |-> !gesture.data.busy_res)
        else $error("wake left the interaction open");

    // a tick taken by the back stage needs a free result slot
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (q_back.valid && q_back.ready && gesture.valid) |-> gesture.ready)
        else $error("result overwritten while stalled");
endmodule
